// ----- rtl/hcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// hcpm_pkg: shared types and constants for the HSV cone palette matcher
// Cone point format, sine table, palette points and pipeline depths.
// ----------------------------------------------------------------------------
package hcpm_pkg;

  localparam int unsigned COORD_FRAC_BITS = 14;
  localparam int unsigned PAL_SIZE        = 12;
  localparam int unsigned LANE_COUNT      = 3;
  localparam int unsigned LANE_STAGES     = 13;
  localparam int unsigned MATCH_STAGES    = 6;
  localparam int unsigned NUM_STAGES      = LANE_STAGES + MATCH_STAGES;

  localparam logic [23:0] AIR_KEY_RESET = 24'hFF00FF;
  localparam logic [0:0]  REG_AIR_KEY   = 1'b0;

  localparam logic [7:0]  BLOCK_NONE = 8'd0;
  localparam logic [7:0]  BLOCK_WOOL = 8'd35;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic signed [15:0] x;
    logic        [14:0] y;
    logic signed [15:0] z;
  } cone_pt_t;

  typedef logic signed [15:0] qsin_tab_t [0:90];

  // shift-and-subtract quotient of two 64-bit values; elaboration only
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned dv);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= dv) begin
        rem  = rem - dv;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(deg) for deg 0..90 by Taylor series at Q30, rounded to Q14
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t          tab;
    longint unsigned    a;
    longint unsigned    term;
    longint             sum;
    for (int i = 0; i <= 90; i++) begin
      a    = (longint'(i) * PI_Q30 + 64'd90) / 64'd180;
      term = a;
      sum  = longint'(a);
      for (int k = 1; k <= 12; k++) begin
        term = udiv64((term * a) >> 30, 64'(2 * k));
        term = udiv64((term * a) >> 30, 64'(2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[i] = 16'((sum + (64'sd1 <<< (29 - COORD_FRAC_BITS))) >>> (30 - COORD_FRAC_BITS));
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

  // full-circle sine from the quarter table
  function automatic logic signed [15:0] sin_lookup(logic [8:0] deg);
    logic [8:0]         off;
    logic signed [15:0] res;
    if (deg <= 9'd90) begin
      res = QSIN[deg[6:0]];
    end else if (deg <= 9'd180) begin
      off = 9'd180 - deg;
      res = QSIN[off[6:0]];
    end else if (deg <= 9'd270) begin
      off = deg - 9'd180;
      res = -QSIN[off[6:0]];
    end else begin
      off = 9'd360 - deg;
      res = -QSIN[off[6:0]];
    end
    return res;
  endfunction

  // rounded n / 65025, ties away from zero; elaboration only
  function automatic logic signed [15:0] rd65025(longint n);
    logic signed [15:0] res;
    if (n >= 0) begin
      res = 16'((n + 32512) / 65025);
    end else begin
      res = -16'((-n + 32512) / 65025);
    end
    return res;
  endfunction

  localparam cone_pt_t PAL_PT [PAL_SIZE] = '{
    '{x: QSIN[30],  y: 15'd16384, z: -QSIN[60]},
    '{x: 16'sd0,    y: 15'd16384, z: 16'sd0},
    '{x: QSIN[61],  y: 15'd16384, z: QSIN[29]},
    '{x: rd65025(-longint'(QSIN[30]) * 32640), y: 15'd16384,
      z: rd65025(-longint'(QSIN[60]) * 32640)},
    '{x: QSIN[30],  y: 15'd16384, z: QSIN[60]},
    '{x: -QSIN[30], y: 15'd16384, z: QSIN[60]},
    '{x: 16'sd0,    y: 15'd4369,  z: 16'sd0},
    '{x: 16'sd0,    y: 15'd11308, z: 16'sd0},
    '{x: -QSIN[30], y: 15'd16384, z: -QSIN[60]},
    '{x: rd65025(longint'(QSIN[60]) * 32640), y: 15'd8224,
      z: rd65025(longint'(QSIN[30]) * 32640)},
    '{x: rd65025(longint'(QSIN[90]) * 52020), y: 15'd13107,
      z: rd65025(longint'(QSIN[0]) * 52020)},
    '{x: 16'sd0,    y: 15'd0,     z: 16'sd0}
  };

  localparam logic [7:0] PAL_BLOCK [PAL_SIZE] = '{
    BLOCK_NONE, BLOCK_WOOL, BLOCK_WOOL, BLOCK_WOOL, BLOCK_WOOL, BLOCK_WOOL,
    BLOCK_WOOL, BLOCK_WOOL, BLOCK_WOOL, BLOCK_WOOL, BLOCK_WOOL, BLOCK_WOOL
  };

  localparam logic [3:0] PAL_DATA [PAL_SIZE] = '{
    4'd0, 4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8, 4'd11, 4'd12, 4'd14, 4'd15
  };

  // reciprocals for constant division
  localparam logic [24:0] RECIP_255   = 25'((64'd1 << 32) / 64'd255 + 64'd1);
  localparam logic [31:0] RECIP_65025 = 32'((64'd1 << 47) / 64'd65025 + 64'd1);
  localparam logic [17:0] RECIP_3     = 18'((64'd1 << 18) / 64'd3 + 64'd1);

endpackage

// ----- rtl/hsv_cone_palette_match.sv -----
// ----------------------------------------------------------------------------
// hsv_cone_palette_match: nearest palette color of a voxel in the HSV cone
// Three views per voxel, air detection, three color lanes and a matcher.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries top, side and front RGB
//   colors of one voxel; output channel (out_valid_o/out_ready_i) returns
//   is_air, block_id and data_value for it, in order.
//   One transaction is accepted per cycle while in_ready_o is high. It reaches
//   out_valid_o through the 19-stage pipeline: 13 lane stages (an input
//   stage, one per hue quotient bit, then lookup, scale and rounding) and 6
//   matcher stages (average, square, sum, 3-level tree).
//   When the receiver stalls, each stage holds only if the one after it is
//   full, so bubbles close up and the input keeps accepting until all 19
//   stages hold a transaction.
//   Reset clears all stage valid bits and loads the air key with 0xFF00FF.
//   The air key is written over the APB port at byte address 0; write it
//   only while no transaction is in flight.
// ----------------------------------------------------------------------------
module hsv_cone_palette_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] top_color_i,
  input  logic [23:0] side_color_i,
  input  logic [23:0] front_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_air_o,
  output logic [7:0]  block_id_o,
  output logic [3:0]  data_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NS = hcpm_pkg::NUM_STAGES;
  localparam int unsigned LS = hcpm_pkg::LANE_STAGES;

  // configuration
  logic [23:0] air_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_key_q <= hcpm_pkg::AIR_KEY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == hcpm_pkg::REG_AIR_KEY)) begin
      air_key_q <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hcpm_pkg::REG_AIR_KEY) ? {8'b0, air_key_q} : 32'b0;

  // stage flow control: a stage loads when empty or when it drains
  logic [NS-1:0] valid_q;
  logic [NS-1:0] load;

  always_comb begin
    load[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NS-1];

  // air flag rides alongside the lanes
  logic air_q [0:LS-1];

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      air_q[0] <= (top_color_i == air_key_q) || (side_color_i == air_key_q) ||
                  (front_color_i == air_key_q);
    end
    for (int k = 1; k < LS; k++) begin
      if (load[k]) begin
        air_q[k] <= air_q[k-1];
      end
    end
  end

  hcpm_pkg::cone_pt_t pts [hcpm_pkg::LANE_COUNT];

  hcpm_lane u_lane_top (
    .clk_i   (clk_i),
    .en_i    (load[LS-1:0]),
    .color_i (top_color_i),
    .pt_o    (pts[0])
  );

  hcpm_lane u_lane_side (
    .clk_i   (clk_i),
    .en_i    (load[LS-1:0]),
    .color_i (side_color_i),
    .pt_o    (pts[1])
  );

  hcpm_lane u_lane_front (
    .clk_i   (clk_i),
    .en_i    (load[LS-1:0]),
    .color_i (front_color_i),
    .pt_o    (pts[2])
  );

  hcpm_match u_match (
    .clk_i        (clk_i),
    .en_i         (load[NS-1:LS]),
    .air_i        (air_q[LS-1]),
    .pt_i         (pts),
    .is_air_o     (is_air_o),
    .block_id_o   (block_id_o),
    .data_value_o (data_value_o)
  );

endmodule

// ----- rtl/hcpm_lane.sv -----
// ----------------------------------------------------------------------------
// hcpm_lane: one RGB color to HSV cone point
// Max/min and hue numerator, bit-per-stage dividers for hue and saturation,
// sine lookup, scale multiply and rounding by 65025.
// ----------------------------------------------------------------------------
module hcpm_lane (
  input  logic                               clk_i,
  input  logic [hcpm_pkg::LANE_STAGES-1:0]   en_i,
  input  logic [23:0]                        color_i,
  output hcpm_pkg::cone_pt_t                 pt_o
);

  // stage 0 combinational
  logic [7:0]         r, g, b, mx, mn, d;
  logic signed [9:0]  rs, gs, bs, ds;
  logic signed [17:0] hh;
  logic [24:0]        hnum;
  logic [21:0]        ny;
  logic [46:0]        yprod;

  always_comb begin
    r  = color_i[23:16];
    g  = color_i[15:8];
    b  = color_i[7:0];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;
    rs = signed'({2'b00, r});
    gs = signed'({2'b00, g});
    bs = signed'({2'b00, b});
    ds = signed'({2'b00, d});
    if (r == mx) begin
      hh = 18'(60 * (gs - bs));
    end else if (g == mx) begin
      hh = 18'(120 * ds + 60 * (bs - rs));
    end else begin
      hh = 18'(240 * ds + 60 * (rs - gs));
    end
    if (hh < 0) begin
      hh = hh + 18'(360 * ds);
    end
    hnum  = 25'(unsigned'(hh)) * 25'd200 + 25'(d);
    ny    = {mx, 14'b0} + 22'd127;
    yprod = 47'(ny) * 47'(hcpm_pkg::RECIP_255);
  end

  // divider pipeline, index 0 is the stage 0 register
  logic [24:0] remh_q [0:9];
  logic [8:0]  qh_q   [0:9];
  logic [24:0] rems_q [0:9];
  logic [7:0]  qs_q   [0:9];
  logic [7:0]  mx_q   [0:9];
  logic [15:0] dh_q   [0:9];
  logic        dz_q   [0:11];
  logic [14:0] y_q    [0:11];

  logic [24:0] remh_d [1:9];
  logic [8:0]  qh_d   [1:9];
  logic [24:0] rems_d [1:9];
  logic [7:0]  qs_d   [1:9];

  always_comb begin
    logic [25:0] shh;
    logic [25:0] shs;
    for (int k = 1; k <= 9; k++) begin
      shs       = '0;
      shh       = 26'(dh_q[k-1]) << (9 - k);
      remh_d[k] = remh_q[k-1];
      qh_d[k]   = qh_q[k-1];
      if ({1'b0, remh_q[k-1]} >= shh) begin
        remh_d[k] = remh_q[k-1] - shh[24:0];
        qh_d[k]   = qh_q[k-1] | (9'd1 << (9 - k));
      end
      rems_d[k] = rems_q[k-1];
      qs_d[k]   = qs_q[k-1];
      if (k <= 8) begin
        shs = 26'({mx_q[k-1], 9'b0}) << (8 - k);
        if ({1'b0, rems_q[k-1]} >= shs) begin
          rems_d[k] = rems_q[k-1] - shs[24:0];
          qs_d[k]   = qs_q[k-1] | 8'(9'd1 << (8 - k));
        end
      end
    end
  end

  // stage 10 combinational: hue fold and table lookup
  logic [8:0]  hue;
  logic [9:0]  cidx;
  logic signed [15:0] sin_d, cos_d;
  logic [15:0] sm_d;

  always_comb begin
    hue  = (qh_q[9] == 9'd360) ? 9'd0 : qh_q[9];
    cidx = {1'b0, hue} + 10'd90;
    if (cidx >= 10'd360) begin
      cidx = cidx - 10'd360;
    end
    sin_d = hcpm_pkg::sin_lookup(hue);
    cos_d = hcpm_pkg::sin_lookup(cidx[8:0]);
    sm_d  = 16'(qs_q[9]) * 16'(mx_q[9]);
  end

  logic signed [15:0] sin_q, cos_q;
  logic [15:0]        sm_q;
  logic signed [32:0] mulx, mulz;
  logic signed [31:0] px_q, pz_q;
  hcpm_pkg::cone_pt_t pt_q;

  assign mulx = cos_q * $signed({1'b0, sm_q});
  assign mulz = sin_q * $signed({1'b0, sm_q});

  // rounded p / 65025, ties away from zero
  function automatic logic signed [15:0] round_65025(logic signed [31:0] p);
    logic        neg;
    logic [30:0] mag;
    logic [62:0] prod;
    logic [15:0] q;
    neg  = p[31];
    mag  = neg ? 31'(-p) : p[30:0];
    mag  = mag + 31'd32512;
    prod = 63'(mag) * 63'(hcpm_pkg::RECIP_65025);
    q    = {1'b0, prod[61:47]};
    return neg ? -signed'(q) : signed'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      remh_q[0] <= hnum;
      qh_q[0]   <= '0;
      rems_q[0] <= 25'(d) * 25'd131070 + 25'(mx);
      qs_q[0]   <= '0;
      mx_q[0]   <= mx;
      dh_q[0]   <= 16'(d) * 16'd200;
      dz_q[0]   <= (d == 8'd0);
      y_q[0]    <= yprod[46:32];
    end
    for (int k = 1; k <= 9; k++) begin
      if (en_i[k]) begin
        remh_q[k] <= remh_d[k];
        qh_q[k]   <= qh_d[k];
        rems_q[k] <= rems_d[k];
        qs_q[k]   <= qs_d[k];
        mx_q[k]   <= mx_q[k-1];
        dh_q[k]   <= dh_q[k-1];
        dz_q[k]   <= dz_q[k-1];
        y_q[k]    <= y_q[k-1];
      end
    end
    if (en_i[10]) begin
      sin_q    <= sin_d;
      cos_q    <= cos_d;
      sm_q     <= sm_d;
      dz_q[10] <= dz_q[9];
      y_q[10]  <= y_q[9];
    end
    if (en_i[11]) begin
      px_q     <= mulx[31:0];
      pz_q     <= mulz[31:0];
      dz_q[11] <= dz_q[10];
      y_q[11]  <= y_q[10];
    end
    if (en_i[12]) begin
      pt_q.x   <= dz_q[11] ? 16'sd0 : round_65025(px_q);
      pt_q.z   <= dz_q[11] ? 16'sd0 : round_65025(pz_q);
      pt_q.y   <= y_q[11];
    end
  end

  assign pt_o = pt_q;

endmodule

// ----- rtl/hcpm_match.sv -----
// ----------------------------------------------------------------------------
// hcpm_match: average three cone points and pick the nearest palette entry
// Rounded divide by three, squared distance per palette entry, registered
// minimum tree that keeps the earlier entry on a tie.
// ----------------------------------------------------------------------------
module hcpm_match (
  input  logic                                clk_i,
  input  logic [hcpm_pkg::MATCH_STAGES-1:0]   en_i,
  input  logic                                air_i,
  input  hcpm_pkg::cone_pt_t                  pt_i [hcpm_pkg::LANE_COUNT],
  output logic                                is_air_o,
  output logic [7:0]                          block_id_o,
  output logic [3:0]                          data_value_o
);

  localparam int unsigned NP = hcpm_pkg::PAL_SIZE;

  // rounded s / 3, ties away from zero
  function automatic logic signed [15:0] div3(logic signed [17:0] s);
    logic        neg;
    logic [16:0] mag;
    logic [34:0] prod;
    logic [15:0] q;
    neg  = s[17];
    mag  = neg ? 17'(-s) : s[16:0];
    mag  = mag + 17'd1;
    prod = 35'(mag) * 35'(hcpm_pkg::RECIP_3);
    q    = {1'b0, prod[32:18]};
    return neg ? -signed'(q) : signed'(q);
  endfunction

  logic signed [17:0] sx, sz;
  logic [16:0]        sy;
  logic [34:0]        yprod;

  always_comb begin
    sx    = 18'(pt_i[0].x) + 18'(pt_i[1].x) + 18'(pt_i[2].x);
    sz    = 18'(pt_i[0].z) + 18'(pt_i[1].z) + 18'(pt_i[2].z);
    sy    = 17'(pt_i[0].y) + 17'(pt_i[1].y) + 17'(pt_i[2].y);
    yprod = 35'(sy + 17'd1) * 35'(hcpm_pkg::RECIP_3);
  end

  hcpm_pkg::cone_pt_t avg_q;
  logic               air_q [0:4];
  logic [30:0]        sqx_q [NP];
  logic [30:0]        sqy_q [NP];
  logic [30:0]        sqz_q [NP];
  logic [31:0]        dist_q [NP];
  logic [31:0]        t1d_q [6];
  logic [3:0]         t1i_q [6];
  logic [31:0]        t2d_q [3];
  logic [3:0]         t2i_q [3];
  logic               air_out_q;
  logic [7:0]         block_q;
  logic [3:0]         data_q;

  logic signed [16:0] dx [NP];
  logic signed [16:0] dz [NP];
  logic signed [15:0] dy [NP];
  logic signed [33:0] px [NP];
  logic signed [33:0] pz [NP];
  logic signed [31:0] py [NP];

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      dx[i] = 17'(avg_q.x) - 17'(hcpm_pkg::PAL_PT[i].x);
      dz[i] = 17'(avg_q.z) - 17'(hcpm_pkg::PAL_PT[i].z);
      dy[i] = signed'({1'b0, avg_q.y}) - signed'({1'b0, hcpm_pkg::PAL_PT[i].y});
      px[i] = dx[i] * dx[i];
      pz[i] = dz[i] * dz[i];
      py[i] = dy[i] * dy[i];
    end
  end

  // final compare of three survivors
  logic [31:0] wd;
  logic [3:0]  wi;
  always_comb begin
    wd = t2d_q[0];
    wi = t2i_q[0];
    if (t2d_q[1] < wd) begin
      wd = t2d_q[1];
      wi = t2i_q[1];
    end
    if (t2d_q[2] < wd) begin
      wi = t2i_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      avg_q.x  <= div3(sx);
      avg_q.z  <= div3(sz);
      avg_q.y  <= yprod[32:18];
      air_q[0] <= air_i;
    end
    if (en_i[1]) begin
      for (int i = 0; i < NP; i++) begin
        sqx_q[i] <= px[i][30:0];
        sqy_q[i] <= py[i][30:0];
        sqz_q[i] <= pz[i][30:0];
      end
      air_q[1] <= air_q[0];
    end
    if (en_i[2]) begin
      for (int i = 0; i < NP; i++) begin
        dist_q[i] <= 32'(sqx_q[i]) + 32'(sqy_q[i]) + 32'(sqz_q[i]);
      end
      air_q[2] <= air_q[1];
    end
    if (en_i[3]) begin
      for (int j = 0; j < 6; j++) begin
        if (dist_q[2*j+1] < dist_q[2*j]) begin
          t1d_q[j] <= dist_q[2*j+1];
          t1i_q[j] <= 4'(2*j+1);
        end else begin
          t1d_q[j] <= dist_q[2*j];
          t1i_q[j] <= 4'(2*j);
        end
      end
      air_q[3] <= air_q[2];
    end
    if (en_i[4]) begin
      for (int j = 0; j < 3; j++) begin
        if (t1d_q[2*j+1] < t1d_q[2*j]) begin
          t2d_q[j] <= t1d_q[2*j+1];
          t2i_q[j] <= t1i_q[2*j+1];
        end else begin
          t2d_q[j] <= t1d_q[2*j];
          t2i_q[j] <= t1i_q[2*j];
        end
      end
      air_q[4] <= air_q[3];
    end
    if (en_i[5]) begin
      air_out_q <= air_q[4];
      block_q   <= air_q[4] ? hcpm_pkg::BLOCK_NONE : hcpm_pkg::PAL_BLOCK[wi];
      data_q    <= air_q[4] ? 4'd0 : hcpm_pkg::PAL_DATA[wi];
    end
  end

  assign is_air_o     = air_out_q;
  assign block_id_o   = block_q;
  assign data_value_o = data_q;

endmodule
